// ----- rtl/core/isort_pkg.sv -----
// shared types and constants for the insertion sorter
package isort_pkg;

    localparam int DEFAULT_MAX_COUNT = 32;
    localparam int VALUE_W           = 32;

    typedef enum logic {
        ST_FILL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctrl;

endpackage

// ----- rtl/core/isort_in_if.sv -----
// input channel of the insertion sorter: one value per item
interface isort_in_if;
    logic                          valid;
    logic                          ready;
    logic [isort_pkg::VALUE_W-1:0] value;
    logic                          last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

// ----- rtl/core/isort_out_if.sv -----
// output channel of the insertion sorter: one sorted value per item
interface isort_out_if;
    logic                          valid;
    logic                          ready;
    logic [isort_pkg::VALUE_W-1:0] sorted_value;
    logic                          end_of_run;
    logic                          overflowed;

    modport source (output valid, output sorted_value, output end_of_run,
                    output overflowed, input ready);
    modport sink   (input valid, input sorted_value, input end_of_run,
                    input overflowed, output ready);
endinterface

// ----- rtl/core/isort_cell.sv -----
// one cell of the sorting chain: holds a value, inserts or shifts as its control selects
module isort_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 6
) (
    input  logic                          i_clk,
    input  isort_pkg::t_cell_ctrl         i_ctrl,
    input  logic [CNT_W-1:0]              i_count,
    input  logic [isort_pkg::VALUE_W-1:0] i_value,
    input  logic [isort_pkg::VALUE_W-1:0] i_left_value,
    input  logic                          i_left_key,
    input  logic [isort_pkg::VALUE_W-1:0] i_right_value,
    output logic [isort_pkg::VALUE_W-1:0] o_value,
    output logic                          o_key
);
    import isort_pkg::*;

    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] n_value;

    // key: this cell is empty or holds a value strictly above the new one
    assign o_key   = (CNT_W'(IDX) >= i_count) || (i_value < r_value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.insert) begin
            if (i_left_key) begin
                n_value = i_left_value;
            end else if (o_key) begin
                n_value = i_value;
            end
        end else if (i_ctrl.shift) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end
endmodule

// ----- rtl/core/insertion_sorter_core.sv -----
// Stable insertion sorter built as a chain of cells. Every value item is inserted into
// the chain as it is accepted: all cells compare against it at once and the larger ones
// move up a place, so i_in.ready stays high through a run and takes one item per cycle.
// An item with the last mark is inserted too and then starts the emit pass, in which the
// chain shifts toward cell 0 and hands out one sorted value per cycle while the output
// accepts them; input is held off during that pass. Values that arrive while all MAX_COUNT
// cells are full are dropped and every result of that run carries overflowed. Equal values
// come out in arrival order.
module insertion_sorter_core #(
    parameter int MAX_COUNT = isort_pkg::DEFAULT_MAX_COUNT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    isort_in_if.sink           i_in,
    isort_out_if.source        o_out
);
    import isort_pkg::*;

    localparam int CNT_W = $clog2(MAX_COUNT + 1);

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_ovf;
    logic               n_ovf;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_end;
    logic               r_out_ovf;

    logic               w_in_ready;
    logic               w_accept;
    logic               w_full;
    logic               w_load;
    t_cell_ctrl         w_ctrl;

    logic [VALUE_W-1:0] w_value [MAX_COUNT];
    logic               w_key   [MAX_COUNT];

    assign w_full   = (r_count == CNT_W'(MAX_COUNT));
    assign w_accept = i_in.valid && w_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_FILL: begin
                if (w_accept && i_in.last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_load && (r_count == CNT_W'(1))) begin
                    n_state = ST_FILL;
                end
            end
            default: n_state = ST_FILL;
        endcase
    end

    // state outputs
    always_comb begin
        w_in_ready  = 1'b0;
        w_load      = 1'b0;
        w_ctrl      = '0;
        unique case (r_state)
            ST_FILL: begin
                w_in_ready    = 1'b1;
                w_ctrl.insert = i_in.valid && !w_full;
            end
            ST_EMIT: begin
                w_load       = !r_out_valid || o_out.ready;
                w_ctrl.shift = w_load;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (w_accept) begin
            if (w_full) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else if (w_load) begin
            n_count = r_count - CNT_W'(1);
            if (r_count == CNT_W'(1)) begin
                n_ovf = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_value <= w_value[0];
            r_out_end   <= (r_count == CNT_W'(1));
            r_out_ovf   <= r_ovf;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_COUNT; gi++) begin : g_cell
            logic [VALUE_W-1:0] w_left_value;
            logic               w_left_key;
            logic [VALUE_W-1:0] w_right_value;

            if (gi == 0) begin : g_head
                assign w_left_value = i_in.value;
                assign w_left_key   = 1'b0;
            end else begin : g_body
                assign w_left_value = w_value[gi-1];
                assign w_left_key   = w_key[gi-1];
            end

            if (gi == MAX_COUNT - 1) begin : g_tail
                assign w_right_value = w_value[gi];
            end else begin : g_mid
                assign w_right_value = w_value[gi+1];
            end

            isort_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl),
                .i_count       (r_count),
                .i_value       (i_in.value),
                .i_left_value  (w_left_value),
                .i_left_key    (w_left_key),
                .i_right_value (w_right_value),
                .o_value       (w_value[gi]),
                .o_key         (w_key[gi])
            );
        end
    endgenerate

    assign i_in.ready         = w_in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.sorted_value = r_out_value;
    assign o_out.end_of_run   = r_out_end;
    assign o_out.overflowed   = r_out_ovf;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_COUNT))
        else $error("stored count above capacity");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_count != '0))
        else $error("emit pass with empty store");

    a_last_starts_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.last) |=> (r_state == ST_EMIT))
        else $error("last item did not start emit pass");

    a_emit_ends_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && (n_state == ST_FILL)) |=>
            (r_out_valid && r_out_end && (r_count == '0) && !r_ovf))
        else $error("run closed without end mark or clean state");
`endif
endmodule
